@@ hw/rtl/hsv2rgb_pkg.sv @@
// shared widths, constants and sector codes for the hsv to rgb pixel converter
// no dependencies; imported by hsv2rgb_scale, hsv_to_rgb_pixel_top and the testbench
package hsv2rgb_pkg;

	localparam int HUE_W    = 14;
	localparam int SECTOR_W = 4;
	localparam int REM_W    = 10;
	localparam int CHAN_W   = 8;

	// highest sector index reachable once hue is folded below two turns
	localparam int SECTOR_MAX = 11;

	localparam logic [HUE_W-1:0] HUE_FULL_TURN = 14'd5760;
	localparam logic [HUE_W-1:0] HUE_SECTOR    = 14'd960;

	// divide by 960 split as shift by 6 then divide by 15
	localparam int DIV_SHIFT = 6;
	localparam int DIV_ODD   = 15;

	localparam logic [SECTOR_W-1:0] SEC_RED_YELLOW    = 4'd0;
	localparam logic [SECTOR_W-1:0] SEC_YELLOW_GREEN  = 4'd1;
	localparam logic [SECTOR_W-1:0] SEC_GREEN_CYAN    = 4'd2;
	localparam logic [SECTOR_W-1:0] SEC_CYAN_BLUE     = 4'd3;
	localparam logic [SECTOR_W-1:0] SEC_BLUE_MAGENTA  = 4'd4;

endpackage

@@ hw/rtl/hsv2rgb_scale.sv @@
// scales one unit-range level to an 8-bit channel: floor(255 * level / 2^F)
// depends on hsv2rgb_pkg
module hsv2rgb_scale
	import hsv2rgb_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input  logic [FRACTION_BITS:0] level,
	output logic [CHAN_W-1:0]      chan
);

	localparam int PROD_W = FRACTION_BITS + 1 + CHAN_W;

	logic [PROD_W-1:0] scaled;

	// 255 * level as (level << 8) - level
	assign scaled = {level, {CHAN_W{1'b0}}} - PROD_W'(level);
	assign chan   = scaled[FRACTION_BITS +: CHAN_W];

endmodule

@@ hw/rtl/hsv_to_rgb_pixel_top.sv @@
// hsv to rgb pixel converter, six-stage pipeline with per-stage valid bits
// a pixel transaction moves through stage registers s1 to s6 in order; rgb_valid rises once it reaches s6
// throughput: one pixel per cycle while rgb_ready stays high; stages refill bubbles while the output stalls
// reset: arst_n clears all stage valid bits at once, payload registers are not reset
// depends on hsv2rgb_pkg and hsv2rgb_scale
module hsv_to_rgb_pixel_top
	import hsv2rgb_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pix_valid,
	output logic                   pix_ready,
	input  logic [HUE_W-1:0]       hue,
	input  logic [FRACTION_BITS:0] saturation,
	input  logic [FRACTION_BITS:0] brightness,
	output logic                   rgb_valid,
	input  logic                   rgb_ready,
	output logic [CHAN_W-1:0]      red,
	output logic [CHAN_W-1:0]      green,
	output logic [CHAN_W-1:0]      blue
);

	localparam int UNIT_W = FRACTION_BITS + 1;
	localparam int PROD_W = 2 * UNIT_W;
	localparam int P_W    = UNIT_W + REM_W;
	// c * weight never exceeds 2^F * 960, so the quotient by 64 fits F + 4 bits
	localparam int Q_W    = FRACTION_BITS + 4;
	localparam int RCP_W  = FRACTION_BITS + 1;
	localparam int MQ_W   = Q_W + RCP_W;
	// reciprocal of 15 scaled by 2^Q_W, rounded down; estimate is at most one low
	localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << Q_W) / 64'd15);
	localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1) << FRACTION_BITS;

	// ---------------------------------------------------------------
	// handshake: each stage takes a new transaction when it is empty
	// or when the stage after it moves on
	// ---------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	assign rdy6 = !vld_s6 || rgb_ready;
	assign rdy5 = !vld_s5 || rdy6;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign pix_ready = rdy1;
	assign rgb_valid = vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= pix_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: saturate s and v to 1.0, fold hue above one full turn
	// ---------------------------------------------------------------
	logic [HUE_W-1:0]  hue_s1;
	logic [UNIT_W-1:0] sat_s1, val_s1;
	logic [HUE_W-1:0]  hue_fold;
	logic [UNIT_W-1:0] sat_clamp, val_clamp;

	always_comb begin
		hue_fold  = (hue > HUE_FULL_TURN) ? hue - HUE_FULL_TURN : hue;
		sat_clamp = (saturation > UNIT_ONE) ? UNIT_ONE : saturation;
		val_clamp = (brightness > UNIT_ONE) ? UNIT_ONE : brightness;
	end

	always_ff @(posedge clk) begin
		if (rdy1 && pix_valid) begin
			hue_s1 <= hue_fold;
			sat_s1 <= sat_clamp;
			val_s1 <= val_clamp;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: chroma c = v * s, sector and in-sector weight from hue
	// odd sectors run downwards, so the weight is 960 minus the remainder
	// ---------------------------------------------------------------
	logic [UNIT_W-1:0]   c_s2, val_s2;
	logic [SECTOR_W-1:0] sector_s2;
	logic [REM_W-1:0]    wgt_s2;
	logic [PROD_W-1:0]   vs_prod;
	logic [SECTOR_W-1:0] sec_sel;
	logic [HUE_W-1:0]    sec_base;
	logic [REM_W-1:0]    rem;
	logic [REM_W-1:0]    wgt;

	always_comb begin
		vs_prod  = PROD_W'(val_s1) * PROD_W'(sat_s1);
		sec_sel  = '0;
		sec_base = '0;
		// independent threshold compares, highest hit wins
		for (int k = 1; k <= SECTOR_MAX; k++) begin
			if (hue_s1 >= HUE_W'(k * HUE_SECTOR)) begin
				sec_sel  = SECTOR_W'(k);
				sec_base = HUE_W'(k * HUE_SECTOR);
			end
		end
		rem = REM_W'(hue_s1 - sec_base);
		wgt = sec_sel[0] ? REM_W'(HUE_SECTOR) - rem : rem;
	end

	always_ff @(posedge clk) begin
		if (rdy2 && vld_s1) begin
			c_s2      <= UNIT_W'(vs_prod >> FRACTION_BITS);
			val_s2    <= val_s1;
			sector_s2 <= sec_sel;
			wgt_s2    <= wgt;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: c * weight, and offset m = v - c
	// ---------------------------------------------------------------
	logic [P_W-1:0]      p_s3;
	logic [UNIT_W-1:0]   c_s3, m_s3;
	logic [SECTOR_W-1:0] sector_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && vld_s2) begin
			p_s3      <= P_W'(c_s2) * P_W'(wgt_s2);
			c_s3      <= c_s2;
			m_s3      <= val_s2 - c_s2;
			sector_s3 <= sector_s2;
		end
	end

	// ---------------------------------------------------------------
	// stage 4: divide by 960 - shift out 64, reciprocal multiply by 1/15
	// ---------------------------------------------------------------
	logic [Q_W-1:0]      q_s4;
	logic [UNIT_W-1:0]   est_s4, c_s4, m_s4;
	logic [SECTOR_W-1:0] sector_s4;
	logic [Q_W-1:0]      q_div;
	logic [MQ_W-1:0]     q_recip;

	always_comb begin
		q_div   = p_s3[DIV_SHIFT +: Q_W];
		q_recip = MQ_W'(q_div) * MQ_W'(RECIP);
	end

	always_ff @(posedge clk) begin
		if (rdy4 && vld_s3) begin
			q_s4      <= q_div;
			est_s4    <= UNIT_W'(q_recip >> Q_W);
			c_s4      <= c_s3;
			m_s4      <= m_s3;
			sector_s4 <= sector_s3;
		end
	end

	// ---------------------------------------------------------------
	// stage 5: one-step correction of the quotient estimate gives x
	// ---------------------------------------------------------------
	logic [UNIT_W-1:0]   x_s5, c_s5, m_s5;
	logic [SECTOR_W-1:0] sector_s5;
	logic [Q_W-1:0]      est_x15;
	logic [Q_W-1:0]      q_left;
	logic [UNIT_W-1:0]   x_fix;

	always_comb begin
		est_x15 = (Q_W'(est_s4) << 4) - Q_W'(est_s4);
		q_left  = q_s4 - est_x15;
		x_fix   = (q_left >= Q_W'(DIV_ODD)) ? est_s4 + UNIT_W'(1) : est_s4;
	end

	always_ff @(posedge clk) begin
		if (rdy5 && vld_s4) begin
			x_s5      <= x_fix;
			c_s5      <= c_s4;
			m_s5      <= m_s4;
			sector_s5 <= sector_s4;
		end
	end

	// ---------------------------------------------------------------
	// stage 6: order (c, x, 0) by sector, add m, scale to 8 bits
	// sector five and above, incl. hue of exactly one turn, takes the
	// magenta-red order
	// ---------------------------------------------------------------
	logic [UNIT_W-1:0] r1, g1, b1;
	logic [UNIT_W-1:0] lev_r, lev_g, lev_b;
	logic [CHAN_W-1:0] chan_r, chan_g, chan_b;
	logic [CHAN_W-1:0] red_s6, green_s6, blue_s6;

	always_comb begin
		case (sector_s5)
			SEC_RED_YELLOW: begin
				r1 = c_s5; g1 = x_s5; b1 = '0;
			end
			SEC_YELLOW_GREEN: begin
				r1 = x_s5; g1 = c_s5; b1 = '0;
			end
			SEC_GREEN_CYAN: begin
				r1 = '0; g1 = c_s5; b1 = x_s5;
			end
			SEC_CYAN_BLUE: begin
				r1 = '0; g1 = x_s5; b1 = c_s5;
			end
			SEC_BLUE_MAGENTA: begin
				r1 = x_s5; g1 = '0; b1 = c_s5;
			end
			default: begin
				r1 = c_s5; g1 = '0; b1 = x_s5;
			end
		endcase
		// component + m never exceeds v, so no carry out of the unit width
		lev_r = r1 + m_s5;
		lev_g = g1 + m_s5;
		lev_b = b1 + m_s5;
	end

	hsv2rgb_scale #(.FRACTION_BITS(FRACTION_BITS)) u_scale_r (.level(lev_r), .chan(chan_r));
	hsv2rgb_scale #(.FRACTION_BITS(FRACTION_BITS)) u_scale_g (.level(lev_g), .chan(chan_g));
	hsv2rgb_scale #(.FRACTION_BITS(FRACTION_BITS)) u_scale_b (.level(lev_b), .chan(chan_b));

	always_ff @(posedge clk) begin
		if (rdy6 && vld_s5) begin
			red_s6   <= chan_r;
			green_s6 <= chan_g;
			blue_s6  <= chan_b;
		end
	end

	assign red   = red_s6;
	assign green = green_s6;
	assign blue  = blue_s6;

endmodule

@@ verif/tb_hsv_to_rgb_pixel_top.sv @@
// self-checking testbench for the hsv to rgb pixel converter, directed table then random pixels
// depends on hsv2rgb_pkg and hsv_to_rgb_pixel_top; carries its own rgb predictor
`timescale 1ns / 100ps

module tb_hsv_to_rgb_pixel_top;
	import hsv2rgb_pkg::*;

	localparam int FRACTION_BITS = 16;
	localparam int LEVEL_W = FRACTION_BITS + 1;
	localparam logic [FRACTION_BITS:0] UNIT_LEVEL = LEVEL_W'(1) << FRACTION_BITS;
	// nominal hue range ends just below two full turns
	localparam int HUE_NOMINAL_MAX = 11519;
	localparam longint unsigned LEVEL_SCALE = 255;
	localparam int RANDOM_PIXELS = 600;
	// cycles with no transaction on either side before the run is abandoned
	localparam int STALL_LIMIT = 2000;
	// long output hold-off that fills the pipeline and stalls the input
	localparam int HOLD_OFF_CYCLES = 250;
	// drain time after the last expected result
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	// one directed pixel; known rows carry a typed-in result, the rest use the predictor
	typedef struct packed {
		logic [HUE_W-1:0]       h;
		logic [FRACTION_BITS:0] sat;
		logic [FRACTION_BITS:0] val;
		logic                   known;
		rgb_t                   want;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   pix_valid;
	logic                   pix_ready;
	logic [HUE_W-1:0]       hue;
	logic [FRACTION_BITS:0] saturation;
	logic [FRACTION_BITS:0] brightness;
	logic                   rgb_valid;
	logic                   rgb_ready;
	logic [CHAN_W-1:0]      red;
	logic [CHAN_W-1:0]      green;
	logic [CHAN_W-1:0]      blue;

	rgb_t pending_rgb_q [$];
	int   mismatch_count = 0;
	int   checked_count  = 0;
	int   directed_count = 0;
	int   random_count   = 0;
	int   clamped_count  = 0;
	int   idle_cycles    = 0;
	// shared between the pixel source and the rgb sink
	bit   burst_mode     = 1'b0;
	bit   hold_request   = 1'b0;

	// primaries and secondaries, hue folding at and above a full turn, level clamping
	stim_row_t directed_rows [0:21] = '{
		'{14'd0,     17'd0,      17'd0,      1'b1, '{8'd0,   8'd0,   8'd0}},
		'{14'd0,     UNIT_LEVEL, 17'd0,      1'b1, '{8'd0,   8'd0,   8'd0}},
		'{14'd0,     17'd0,      UNIT_LEVEL, 1'b1, '{8'd255, 8'd255, 8'd255}},
		'{14'd0,     UNIT_LEVEL, UNIT_LEVEL, 1'b1, '{8'd255, 8'd0,   8'd0}},
		'{14'd960,   UNIT_LEVEL, UNIT_LEVEL, 1'b1, '{8'd255, 8'd255, 8'd0}},
		'{14'd1920,  UNIT_LEVEL, UNIT_LEVEL, 1'b1, '{8'd0,   8'd255, 8'd0}},
		'{14'd2880,  UNIT_LEVEL, UNIT_LEVEL, 1'b1, '{8'd0,   8'd255, 8'd255}},
		'{14'd3840,  UNIT_LEVEL, UNIT_LEVEL, 1'b1, '{8'd0,   8'd0,   8'd255}},
		'{14'd4800,  UNIT_LEVEL, UNIT_LEVEL, 1'b1, '{8'd255, 8'd0,   8'd255}},
		// exactly one full turn stays unfolded and lands in the last case
		'{14'd5760,  UNIT_LEVEL, UNIT_LEVEL, 1'b1, '{8'd255, 8'd0,   8'd0}},
		'{14'd11520, UNIT_LEVEL, UNIT_LEVEL, 1'b1, '{8'd255, 8'd0,   8'd0}},
		'{14'd5761,  UNIT_LEVEL, UNIT_LEVEL, 1'b0, '0},
		'{14'd959,   UNIT_LEVEL, UNIT_LEVEL, 1'b0, '0},
		'{14'd11519, UNIT_LEVEL, UNIT_LEVEL, 1'b0, '0},
		'{14'd16383, UNIT_LEVEL, UNIT_LEVEL, 1'b0, '0},
		'{14'd16383, 17'h1FFFF,  17'h1FFFF,  1'b0, '0},
		'{14'd480,   17'd65537,  UNIT_LEVEL, 1'b0, '0},
		'{14'd3000,  UNIT_LEVEL, 17'h1FFFF,  1'b0, '0},
		'{14'd7000,  17'd32768,  17'd40000,  1'b0, '0},
		'{14'h2AAA,  17'h15555,  17'h0AAAA,  1'b0, '0},
		'{14'h1555,  17'h0AAAA,  17'h15555,  1'b0, '0},
		'{14'd2000,  17'd1,      17'd1,      1'b0, '0}
	};

	hsv_to_rgb_pixel_top #(
		.FRACTION_BITS(FRACTION_BITS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.hue       (hue),
		.saturation(saturation),
		.brightness(brightness),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// expected rgb for one hsv pixel
	function automatic rgb_t predict_rgb(input logic [HUE_W-1:0] h_in,
			input logic [FRACTION_BITS:0] s_in, input logic [FRACTION_BITS:0] v_in);
		longint unsigned h, s, v, chroma, second, offset, sector, rem, r1, g1, b1;
		rgb_t px;
		h = h_in;
		// a single fold only; exactly one turn is left alone
		if (h > HUE_FULL_TURN)
			h -= HUE_FULL_TURN;
		s = (s_in > UNIT_LEVEL) ? UNIT_LEVEL : s_in;
		v = (v_in > UNIT_LEVEL) ? UNIT_LEVEL : v_in;
		chroma = (v * s) >> FRACTION_BITS;
		offset = v - chroma;
		sector = h / HUE_SECTOR;
		rem    = h % HUE_SECTOR;
		// rising edge of the ramp in even sectors, falling in odd ones
		if (sector[0] == 1'b0)
			second = (chroma * rem) / HUE_SECTOR;
		else
			second = (chroma * (HUE_SECTOR - rem)) / HUE_SECTOR;
		case (sector)
			SEC_RED_YELLOW: begin
				r1 = chroma; g1 = second; b1 = 0;
			end
			SEC_YELLOW_GREEN: begin
				r1 = second; g1 = chroma; b1 = 0;
			end
			SEC_GREEN_CYAN: begin
				r1 = 0; g1 = chroma; b1 = second;
			end
			SEC_CYAN_BLUE: begin
				r1 = 0; g1 = second; b1 = chroma;
			end
			SEC_BLUE_MAGENTA: begin
				r1 = second; g1 = 0; b1 = chroma;
			end
			// magenta-red and every sector past a full turn
			default: begin
				r1 = chroma; g1 = 0; b1 = second;
			end
		endcase
		px.red   = CHAN_W'(((r1 + offset) * LEVEL_SCALE) >> FRACTION_BITS);
		px.green = CHAN_W'(((g1 + offset) * LEVEL_SCALE) >> FRACTION_BITS);
		px.blue  = CHAN_W'(((b1 + offset) * LEVEL_SCALE) >> FRACTION_BITS);
		return px;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// drives valid low for the requested gap, then holds the pixel until the transaction
	task automatic offer_pixel(input logic [HUE_W-1:0] h, input logic [FRACTION_BITS:0] s,
			input logic [FRACTION_BITS:0] v, input rgb_t want, input int gap);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid  <= 1'b1;
		hue        <= h;
		saturation <= s;
		brightness <= v;
		do @(posedge clk); while (!pix_ready);
		pending_rgb_q.push_back(want);
		if (h > HUE_NOMINAL_MAX || s > UNIT_LEVEL || v > UNIT_LEVEL)
			clamped_count++;
	endtask

	// pixel source: directed table, a full drain, then random pixels
	initial begin
		stim_row_t row;
		rgb_t want;
		logic [HUE_W-1:0] h;
		logic [FRACTION_BITS:0] s, v;
		int gap;
		arst_n     <= 1'b0;
		pix_valid  <= 1'b0;
		hue        <= '0;
		saturation <= '0;
		brightness <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(directed_rows); i++) begin
			row = directed_rows[i];
			want = row.known ? row.want : predict_rgb(row.h, row.sat, row.val);
			offer_pixel(row.h, row.sat, row.val, want, int'($urandom_range(0, 18)));
			directed_count++;
		end

		// sender pause: let every directed result come back before going on
		pix_valid <= 1'b0;
		while (pending_rgb_q.size() != 0) @(posedge clk);

		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			// back-to-back stretches; the first one coincides with the long output hold-off
			burst_mode = (i >= 100 && i < 160) || (i >= 350 && i < 420);
			if (i == 100)
				hold_request = 1'b1;
			if ($urandom_range(0, 99) < 85) begin
				// nominal ranges, leaning on sector boundaries and level extremes
				if ($urandom_range(0, 7) == 0)
					h = HUE_W'(HUE_SECTOR * $urandom_range(0, 12));
				else
					h = HUE_W'($urandom_range(0, HUE_NOMINAL_MAX));
				case ($urandom_range(0, 7))
					0:       s = '0;
					1:       s = UNIT_LEVEL;
					default: s = LEVEL_W'($urandom_range(0, UNIT_LEVEL));
				endcase
				case ($urandom_range(0, 7))
					0:       v = '0;
					1:       v = UNIT_LEVEL;
					default: v = LEVEL_W'($urandom_range(0, UNIT_LEVEL));
				endcase
			end else begin
				// any bit pattern: hue past two turns, levels above one
				h = HUE_W'($urandom());
				s = LEVEL_W'($urandom());
				v = LEVEL_W'($urandom());
			end
			gap = burst_mode ? 0 : int'($urandom_range(0, 18));
			offer_pixel(h, s, v, predict_rgb(h, s, v), gap);
			random_count++;
		end
		burst_mode = 1'b0;
		pix_valid <= 1'b0;

		while (pending_rgb_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d directed and %0d random pixels, %0d rgb results checked",
			directed_count, random_count, checked_count);
		$display("%0d pixels had hue or levels outside the nominal range, %0d mismatches",
			clamped_count, mismatch_count);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// rgb sink: random back-pressure, one long hold-off on request
	initial begin
		rgb_t want;
		int stall;
		rgb_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				stall = HOLD_OFF_CYCLES;
			end else begin
				stall = burst_mode ? 0 : int'($urandom_range(0, 18));
			end
			if (stall > 0) begin
				rgb_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rgb_ready <= 1'b1;
			do @(posedge clk); while (!rgb_valid);
			if (pending_rgb_q.size() == 0) begin
				report_mismatch($sformatf("rgb transaction %0d/%0d/%0d with no pixel pending",
					red, green, blue));
			end else begin
				want = pending_rgb_q.pop_front();
				if (red !== want.red)
					report_mismatch($sformatf("red got %0d expected %0d", red, want.red));
				if (green !== want.green)
					report_mismatch($sformatf("green got %0d expected %0d", green, want.green));
				if (blue !== want.blue)
					report_mismatch($sformatf("blue got %0d expected %0d", blue, want.blue));
				checked_count++;
			end
		end
	end

	// watchdog: counts cycles with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_valid && pix_ready) || (rgb_valid && rgb_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: %0d cycles without a transaction, %0d results outstanding",
					idle_cycles, pending_rgb_q.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

endmodule

@@ sim.f @@
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv2rgb_scale.sv
hw/rtl/hsv_to_rgb_pixel_top.sv
verif/tb_hsv_to_rgb_pixel_top.sv
